[rtl/swcs_pkg.sv]
// shared widths, stage indexes, register indexes and the stage-to-stage sum bundle
package swcs_pkg;

    localparam int COORD_BITS   = 24;
    localparam int RADIUS_BITS  = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_PROJ_RADIUS  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_ENEMY_RADIUS = CFG_IDX_BITS'(1);

    // pipeline stages
    localparam int NUM_STAGES = 7;
    localparam int ST_DIFF    = 0;
    localparam int ST_PROD    = 1;
    localparam int ST_SUM     = 2;
    localparam int ST_CLASS   = 3;
    localparam int ST_PART    = 4;
    localparam int ST_ACC     = 5;
    localparam int ST_OUT     = 6;

    // coordinate differences, their products and sums
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    // magnitude of len2, squared distances and |cross|
    localparam int MAG_W  = 2 * COORD_BITS + 1;
    localparam int HALF_W = (MAG_W + 1) / 2;
    localparam int HIGH_W = MAG_W - HALF_W;

    // combined radius and its square
    localparam int RAD_W  = RADIUS_BITS + 1;
    localparam int R2_W   = 2 * RAD_W;

    // final compare of cross^2 against r^2 * len2
    localparam int SQ_W   = 2 * MAG_W;
    localparam int RL_W   = R2_W + MAG_W;
    localparam int CMP_W  = (SQ_W > RL_W) ? SQ_W : RL_W;

    typedef struct packed {
        logic        [MAG_W-1:0] len2;
        logic signed [SUM_W-1:0] dot;
        logic signed [SUM_W-1:0] cross_prod;
        logic        [MAG_W-1:0] dist_s2;
        logic        [MAG_W-1:0] dist_e2;
        logic        [R2_W-1:0]  r2;
    } t_sums;

endpackage

[rtl/swcs_pipe_ctrl.sv]
// valid bits and per-stage load enables of the hit test pipeline
module swcs_pipe_ctrl
    import swcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_ready,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic [NUM_STAGES-1:0] o_load
);

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES-1:0] load;

    // a stage takes new data when empty or when it drains this cycle
    always_comb begin
        load[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || i_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            load[k] = !r_valid[k] || load[k+1];
        end
        n_valid[0] = load[0] ? i_valid : r_valid[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_valid[k] = load[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ready = load[0];
    assign o_valid = r_valid[NUM_STAGES-1];
    assign o_load  = load;

endmodule

[rtl/swcs_front.sv]
// front stages: coordinate differences, 25x25 products, dot/cross/length sums
module swcs_front
    import swcs_pkg::*;
(
    input  logic                         i_clk,
    input  logic [NUM_STAGES-1:0]        i_load,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic [RAD_W-1:0]             i_rad,
    output t_sums                        o_sums
);

    // differences
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_apx, r_apy, r_bpx, r_bpy;
    logic [RAD_W-1:0]         r_rad;

    always_ff @(posedge i_clk) begin
        if (i_load[ST_DIFF]) begin
            r_dx  <= DIFF_W'(i_end_x)   - DIFF_W'(i_start_x);
            r_dy  <= DIFF_W'(i_end_y)   - DIFF_W'(i_start_y);
            r_apx <= DIFF_W'(i_point_x) - DIFF_W'(i_start_x);
            r_apy <= DIFF_W'(i_point_y) - DIFF_W'(i_start_y);
            r_bpx <= DIFF_W'(i_point_x) - DIFF_W'(i_end_x);
            r_bpy <= DIFF_W'(i_point_y) - DIFF_W'(i_end_y);
            r_rad <= i_rad;
        end
    end

    // products
    logic signed [PROD_W-1:0] r_dxdx, r_dydy, r_apxdx, r_apydy, r_dxapy, r_dyapx;
    logic signed [PROD_W-1:0] r_apxapx, r_apyapy, r_bpxbpx, r_bpybpy;
    logic [R2_W-1:0]          r_r2;

    always_ff @(posedge i_clk) begin
        if (i_load[ST_PROD]) begin
            r_dxdx   <= r_dx * r_dx;
            r_dydy   <= r_dy * r_dy;
            r_apxdx  <= r_apx * r_dx;
            r_apydy  <= r_apy * r_dy;
            r_dxapy  <= r_dx * r_apy;
            r_dyapx  <= r_dy * r_apx;
            r_apxapx <= r_apx * r_apx;
            r_apyapy <= r_apy * r_apy;
            r_bpxbpx <= r_bpx * r_bpx;
            r_bpybpy <= r_bpy * r_bpy;
            r_r2     <= r_rad * r_rad;
        end
    end

    // sums, squared terms are never negative and fit the magnitude width
    t_sums n_sums;
    t_sums r_sums;

    always_comb begin
        n_sums.len2       = MAG_W'(r_dxdx + r_dydy);
        n_sums.dot        = SUM_W'(r_apxdx) + SUM_W'(r_apydy);
        n_sums.cross_prod = SUM_W'(r_dxapy) - SUM_W'(r_dyapx);
        n_sums.dist_s2    = MAG_W'(r_apxapx + r_apyapy);
        n_sums.dist_e2    = MAG_W'(r_bpxbpx + r_bpybpy);
        n_sums.r2         = r_r2;
    end

    always_ff @(posedge i_clk) begin
        if (i_load[ST_SUM]) begin
            r_sums <= n_sums;
        end
    end

    assign o_sums = r_sums;

endmodule

[rtl/swcs_back.sv]
// back stages: end-point classification, split wide squares, final compare
module swcs_back
    import swcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic [NUM_STAGES-1:0] i_load,
    input  t_sums                 i_sums,
    output logic                  o_hit
);

    // classification and |cross|
    logic                     zero_len, dot_le0, len_le_dot, s_hit, e_hit;
    logic signed [SUM_W-1:0]  cross_abs;
    logic                     r_cls_end, r_cls_end_hit;
    logic [MAG_W-1:0]         r_cls_mag, r_cls_len2;
    logic [R2_W-1:0]          r_cls_r2;

    always_comb begin
        zero_len   = (i_sums.len2 == '0);
        dot_le0    = i_sums.dot[SUM_W-1] || (i_sums.dot == '0);
        len_le_dot = $signed(SUM_W'(i_sums.len2)) <= i_sums.dot;
        s_hit      = CMP_W'(i_sums.dist_s2) <= CMP_W'(i_sums.r2);
        e_hit      = CMP_W'(i_sums.dist_e2) <= CMP_W'(i_sums.r2);
        cross_abs  = i_sums.cross_prod[SUM_W-1] ? -i_sums.cross_prod : i_sums.cross_prod;
    end

    always_ff @(posedge i_clk) begin
        if (i_load[ST_CLASS]) begin
            r_cls_end     <= zero_len || dot_le0 || len_le_dot;
            // zero length measures to the end point
            r_cls_end_hit <= (!zero_len && dot_le0) ? s_hit : e_hit;
            r_cls_mag     <= cross_abs[MAG_W-1:0];
            r_cls_len2    <= i_sums.len2;
            r_cls_r2      <= i_sums.r2;
        end
    end

    // partial products of cross^2 and r^2 * len2
    logic [2*HIGH_W-1:0]        r_pp_p_hh;
    logic [HIGH_W+HALF_W-1:0]   r_pp_p_hl;
    logic [2*HALF_W-1:0]        r_pp_p_ll;
    logic [RAD_W+HIGH_W-1:0]    r_pp_q_hh, r_pp_q_lh;
    logic [RAD_W+HALF_W-1:0]    r_pp_q_hl, r_pp_q_ll;
    logic                       r_pp_end, r_pp_end_hit;

    always_ff @(posedge i_clk) begin
        if (i_load[ST_PART]) begin
            r_pp_p_hh    <= r_cls_mag[MAG_W-1:HALF_W] * r_cls_mag[MAG_W-1:HALF_W];
            r_pp_p_hl    <= r_cls_mag[MAG_W-1:HALF_W] * r_cls_mag[HALF_W-1:0];
            r_pp_p_ll    <= r_cls_mag[HALF_W-1:0] * r_cls_mag[HALF_W-1:0];
            r_pp_q_hh    <= r_cls_r2[R2_W-1:RAD_W] * r_cls_len2[MAG_W-1:HALF_W];
            r_pp_q_hl    <= r_cls_r2[R2_W-1:RAD_W] * r_cls_len2[HALF_W-1:0];
            r_pp_q_lh    <= r_cls_r2[RAD_W-1:0] * r_cls_len2[MAG_W-1:HALF_W];
            r_pp_q_ll    <= r_cls_r2[RAD_W-1:0] * r_cls_len2[HALF_W-1:0];
            r_pp_end     <= r_cls_end;
            r_pp_end_hit <= r_cls_end_hit;
        end
    end

    // accumulate partial products
    logic [CMP_W-1:0] n_acc_sq, n_acc_rl;
    logic [CMP_W-1:0] r_acc_sq, r_acc_rl;
    logic             r_acc_end, r_acc_end_hit;

    always_comb begin
        n_acc_sq = (CMP_W'(r_pp_p_hh) << (2 * HALF_W))
                 + (CMP_W'(r_pp_p_hl) << (HALF_W + 1))
                 + CMP_W'(r_pp_p_ll);
        n_acc_rl = (CMP_W'(r_pp_q_hh) << (RAD_W + HALF_W))
                 + (CMP_W'(r_pp_q_hl) << RAD_W)
                 + (CMP_W'(r_pp_q_lh) << HALF_W)
                 + CMP_W'(r_pp_q_ll);
    end

    always_ff @(posedge i_clk) begin
        if (i_load[ST_ACC]) begin
            r_acc_sq      <= n_acc_sq;
            r_acc_rl      <= n_acc_rl;
            r_acc_end     <= r_pp_end;
            r_acc_end_hit <= r_pp_end_hit;
        end
    end

    // output register
    logic r_hit;

    always_ff @(posedge i_clk) begin
        if (i_load[ST_OUT]) begin
            r_hit <= r_acc_end ? r_acc_end_hit : (r_acc_sq <= r_acc_rl);
        end
    end

    assign o_hit = r_hit;

endmodule

[rtl/swept_circle_segment_hit_test.sv]
// top level of the swept circle against point hit test
//
// Each beat carries a movement segment S..E and a target point P in signed
// Q16.8; the result beat carries hit, set when the nearest point of the
// segment lies within projectile_radius + enemy_radius of P (<= test, exact,
// no rounding). The block accepts one beat per clock while o_ready is high
// and returns results in order through seven register stages (differences,
// 25x25 products, sums, end-point classification, partial products of the
// ~100 bit squares, their accumulation, the final compare). Each stage holds
// when the stage after it is full and stalled, so empty slots are squeezed
// out and o_ready only drops once all seven stages hold results. The radius
// registers are sampled as a beat enters, so write them only while nothing
// is in flight.
module swept_circle_segment_hit_test
    import swcs_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [RADIUS_BITS-1:0]       i_cfg_data,
    // input beats
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    // result beats
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_hit
);

    // radius registers, unknown indexes are dropped
    logic [RADIUS_BITS-1:0] r_proj_radius;
    logic [RADIUS_BITS-1:0] r_enemy_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proj_radius  <= '0;
            r_enemy_radius <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PROJ_RADIUS: begin
                    r_proj_radius <= i_cfg_data;
                end
                REG_ENEMY_RADIUS: begin
                    r_enemy_radius <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // both radii share the 8 fraction bits, so the sum is a plain add
    logic [RAD_W-1:0] rad_sum;
    assign rad_sum = RAD_W'(r_proj_radius) + RAD_W'(r_enemy_radius);

    // per-stage load enables
    logic [NUM_STAGES-1:0] load;

    swcs_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_load  (load)
    );

    // differences, products and sums
    t_sums sums;

    swcs_front u_front (
        .i_clk     (i_clk),
        .i_load    (load),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_rad     (rad_sum),
        .o_sums    (sums)
    );

    // end-point cases and the interior cross^2 <= r^2 * len2 test
    swcs_back u_back (
        .i_clk  (i_clk),
        .i_load (load),
        .i_sums (sums),
        .o_hit  (o_hit)
    );

endmodule

[rtl/swcs_checker.sv]
// port-level checks of the hit test pipeline, bound to the top level
module swcs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_hit
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat shown right after reset");

    // a drained output frees every stage, so input is taken
    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input refused while output side is ready");

    // input is refused only when a result is stuck at the output
    a_refuse_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input refused with no stalled result");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_hit)))
        else $error("stalled result beat changed or vanished");

endmodule

bind swept_circle_segment_hit_test swcs_checker u_swcs_checker (.*);
